// ----- hdl/serial_time_set_command_parser_top_defines.svh -----
// Assertion macros shared by the checker of the set-time command parser.
// No dependencies; included by files that carry concurrent assertions.
`ifndef SERIAL_TIME_SET_COMMAND_PARSER_TOP_DEFINES_SVH
`define SERIAL_TIME_SET_COMMAND_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STCP_ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("stcp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define STCP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("stcp assertion failed");

`endif

// ----- hdl/stcp_pkg.sv -----
// Shared types and constants of the serial set-time command parser.
// No dependencies; imported by every module of the block.
package stcp_pkg;

  localparam int unsigned PosW       = 5;
  localparam int unsigned LastPlace  = 22;
  localparam int unsigned CommitPlace = 23;
  localparam int unsigned NumDigits  = LastPlace;

  localparam logic [7:0] ChPrint = 8'h67;  // 'g'
  localparam logic [7:0] ChSet   = 8'h73;  // 's'
  localparam logic [7:0] ChDebug = 8'h64;  // 'd'
  localparam logic [7:0] ChBoot  = 8'h62;  // 'b'
  localparam logic [7:0] ChColon = 8'h3A;  // ':'
  localparam logic [7:0] ChDot   = 8'h2E;  // '.'
  localparam logic [7:0] ChSpace = 8'h20;  // ' '
  localparam logic [7:0] ChDash  = 8'h2D;  // '-'
  localparam logic [7:0] ChZero  = 8'h30;  // '0'
  localparam logic [7:0] ChNine  = 8'h39;  // '9'

  localparam logic [PosW-1:0] PosIdle    = 5'd0;
  localparam logic [PosW-1:0] PosFirst   = 5'd1;
  localparam logic [PosW-1:0] PosHmSep   = 5'd3;
  localparam logic [PosW-1:0] PosMsSep   = 5'd6;
  localparam logic [PosW-1:0] PosFracSep = 5'd9;
  localparam logic [PosW-1:0] PosDateSep = 5'd12;
  localparam logic [PosW-1:0] PosDmSep   = 5'd15;
  localparam logic [PosW-1:0] PosMySep   = 5'd18;
  localparam logic [PosW-1:0] PosLast    = 5'(LastPlace);
  localparam logic [PosW-1:0] PosCommit  = 5'(CommitPlace);

  typedef enum logic [1:0] {
    EvNone  = 2'd0,
    EvPrint = 2'd1,
    EvSet   = 2'd2,
    EvBoot  = 2'd3
  } event_e;

  // Per-byte control from the sequencer to the digit store and output stage.
  typedef struct packed {
    event_e          evt;
    logic            echo;
    logic            wr_en;
    logic [PosW-1:0] wr_idx;
    logic [3:0]      digit;
  } seq_ctl_t;

  // Expected separator at a pattern place, zero where a digit belongs.
  function automatic logic [7:0] sep_at(input logic [PosW-1:0] pos);
    logic [7:0] sep;
    unique case (pos)
      PosHmSep, PosMsSep: sep = ChColon;
      PosFracSep:         sep = ChDot;
      PosDateSep:         sep = ChSpace;
      PosDmSep, PosMySep: sep = ChDash;
      default:            sep = 8'h00;
    endcase
    return sep;
  endfunction

endpackage

// ----- hdl/stcp_seq.sv -----
// Command sequencer: pattern position and debug flag, per-byte decode.
// Depends on stcp_pkg.
module stcp_seq import stcp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output seq_ctl_t   ctl_o,
  output logic       debug_o
);

  logic [PosW-1:0] pos_q, pos_d;
  logic            debug_q, debug_d;
  logic [7:0]      sep;
  logic            is_digit;
  logic            ok;

  always_comb begin
    sep          = sep_at(pos_q);
    is_digit     = (byte_i >= ChZero) && (byte_i <= ChNine);
    ok           = 1'b0;
    pos_d        = pos_q;
    debug_d      = debug_q;
    ctl_o.evt    = EvNone;
    ctl_o.echo   = 1'b0;
    ctl_o.wr_en  = 1'b0;
    ctl_o.wr_idx = pos_q - PosFirst;
    ctl_o.digit  = byte_i[3:0];  // '0'..'9' carry their value in the low nibble
    priority if (pos_q == PosIdle) begin
      // any other idle byte is dropped
      if (byte_i == ChPrint) begin
        ctl_o.evt = EvPrint;
      end else if (byte_i == ChSet) begin
        pos_d = PosFirst;
      end else if (byte_i == ChDebug) begin
        debug_d = ~debug_q;
      end else if (byte_i == ChBoot) begin
        ctl_o.evt = EvBoot;
      end
    end else if (pos_q <= PosLast) begin
      ok = (sep != 8'h00) ? (byte_i == sep) : is_digit;
      ctl_o.echo  = ok;
      ctl_o.wr_en = ok && (sep == 8'h00);
      if (ok) begin
        pos_d = pos_q + PosFirst;
      end
    end else if (pos_q == PosCommit) begin
      ctl_o.evt = EvSet;
      pos_d     = PosIdle;
    end else begin
      pos_d = PosIdle;  // unreachable codes fall back to idle
    end
  end

  assign debug_o = debug_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= PosIdle;
      debug_q <= 1'b0;
    end else if (step_i) begin
      pos_q   <= pos_d;
      debug_q <= debug_d;
    end
  end

endmodule

// ----- hdl/stcp_dstore.sv -----
// Digit store of the set-time pattern and the decoded time/date fields.
// Depends on stcp_pkg.
module stcp_dstore import stcp_pkg::*; (
  input  logic        clk_i,
  input  logic        step_i,
  input  seq_ctl_t    ctl_i,
  output logic [6:0]  hours_o,
  output logic [6:0]  minutes_o,
  output logic [6:0]  seconds_o,
  output logic [6:0]  hundredths_o,
  output logic [6:0]  day_o,
  output logic [6:0]  month_o,
  output logic [13:0] year_o
);

  logic [3:0] digit_q [NumDigits];
  logic [6:0] century;
  logic [6:0] yr_low;

  // Entries hold no reset value; each digit entry is written before the commit reads it.
  always_ff @(posedge clk_i) begin
    if (step_i && ctl_i.wr_en) begin
      digit_q[ctl_i.wr_idx] <= ctl_i.digit;
    end
  end

  function automatic logic [6:0] pair(input logic [3:0] tens, input logic [3:0] units);
    return 7'(({3'd0, tens} * 7'd10) + {3'd0, units});
  endfunction

  always_comb begin
    hours_o      = pair(digit_q[0],  digit_q[1]);
    minutes_o    = pair(digit_q[3],  digit_q[4]);
    seconds_o    = pair(digit_q[6],  digit_q[7]);
    hundredths_o = pair(digit_q[9],  digit_q[10]);
    day_o        = pair(digit_q[12], digit_q[13]);
    month_o      = pair(digit_q[15], digit_q[16]);
    century      = pair(digit_q[18], digit_q[19]);
    yr_low       = pair(digit_q[20], digit_q[21]);
    year_o       = 14'(({7'd0, century} * 14'd100) + {7'd0, yr_low});
  end

endmodule

// ----- hdl/serial_time_set_command_parser_top.sv -----
// Top level of the serial set-time command parser: input and result registers.
// Depends on stcp_pkg, stcp_seq and stcp_dstore.
//
// Takes one received byte per transaction and returns exactly one result per
// byte. Idle bytes 'g', 'b' give print and boot events, 'd' toggles the debug
// flag, 's' opens the pattern HH:MM:SS.hh DD-MM-YYYY; matching bytes are echoed,
// others dropped silently, and the byte after the last year digit commits the
// fields with a set event. Throughput is one byte per clock unless m_axis_tready
// stalls the result register; a byte passes the input register, then the result
// register; position register and digit store update as the byte moves across.
module serial_time_set_command_parser_top import stcp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [7:0] echo_byte, [14:8] hours, [21:15] minutes,
                                      // [28:22] seconds, [35:29] hundredths, [42:36] day,
                                      // [49:43] month, [63:50] year, [64] debug_mode
  output logic [2:0]  m_axis_tuser    // [1:0] event_res, [2] echo_valid
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       advance;
  logic       out_valid_q, out_valid_d;
  logic [71:0] out_data_q, out_data_d;
  logic [2:0]  out_user_q, out_user_d;

  seq_ctl_t    ctl;
  logic        debug;
  logic [6:0]  hours, minutes, seconds, hundredths, day, month;
  logic [13:0] year;
  logic        is_set;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  stcp_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .byte_i  (in_byte_q),
    .ctl_o   (ctl),
    .debug_o (debug)
  );

  stcp_dstore u_dstore (
    .clk_i        (clk_i),
    .step_i       (advance),
    .ctl_i        (ctl),
    .hours_o      (hours),
    .minutes_o    (minutes),
    .seconds_o    (seconds),
    .hundredths_o (hundredths),
    .day_o        (day),
    .month_o      (month),
    .year_o       (year)
  );

  assign is_set = (ctl.evt == EvSet);

  always_comb begin
    out_user_d = {ctl.echo, ctl.evt};
    out_data_d = '0;
    out_data_d[7:0]   = ctl.echo ? in_byte_q : 8'h00;
    if (is_set) begin
      out_data_d[14:8]  = hours;
      out_data_d[21:15] = minutes;
      out_data_d[28:22] = seconds;
      out_data_d[35:29] = hundredths;
      out_data_d[42:36] = day;
      out_data_d[49:43] = month;
      out_data_d[63:50] = year;
    end
    out_data_d[64] = debug;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

// ----- hdl/stcp_checker.sv -----
// Port-level checker of the set-time command parser, bound to the top level.
// Depends on stcp_pkg and serial_time_set_command_parser_top_defines.svh.
`include "serial_time_set_command_parser_top_defines.svh"

module stcp_checker import stcp_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);

  // A stalled result holds.
  `STCP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // An echoed byte never carries an event.
  `STCP_ASSERT_IMPL(a_echo_no_event, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[2], m_axis_tuser[1:0] == EvNone)

  // Decoded time fields are zero unless the transaction commits a set.
  `STCP_ASSERT_IMPL(a_fields_only_on_set, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser[1:0] != EvSet), m_axis_tdata[63:8] == 56'd0)

  // Without echo the echo byte is zero.
  `STCP_ASSERT_IMPL(a_no_echo_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser[2], m_axis_tdata[7:0] == 8'h00)

endmodule

bind serial_time_set_command_parser_top stcp_checker u_stcp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
